// File: hw/rtl/mbp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers of the MSB-first bit packer.
package mbp_pkg;

    // Input modes
    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_RAW    = 3'd1;
    localparam logic [2:0] MODE_RANGED = 3'd2;
    localparam logic [2:0] MODE_ALIGN  = 3'd3;
    localparam logic [2:0] MODE_FLUSH  = 3'd4;

    // Commands passed from front to back
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_ALIGN = 3'd2;
    localparam logic [2:0] CMD_FLUSH = 3'd3;
    localparam logic [2:0] CMD_NOP   = 3'd4;

    localparam int BUFFER_BYTES   = 65536;
    localparam int MAX_FIELD_BITS = 32;
    localparam int CAP_RESET      = 1024;
    localparam int CMD_DEPTH_DEF  = 4;
    localparam int OUT_DEPTH      = 2;

    // Smallest of BUFFER_BYTES and the 16-bit address space
    localparam int CAP_LIMIT_INT = (BUFFER_BYTES > 65536) ? 65536 : BUFFER_BYTES;
    localparam logic [16:0] CAP_LIMIT = 17'(CAP_LIMIT_INT);

    typedef struct packed {
        logic [2:0]         mode;
        logic [31:0]        value;
        logic [5:0]         bit_count;
        logic signed [31:0] range_min;
        logic signed [31:0] range_max;
    } in_t;

    typedef struct packed {
        logic        byte_valid;
        logic [15:0] byte_address;
        logic [7:0]  byte_data;
        logic        overflow;
        logic [19:0] bits_written;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] data;
        logic [5:0]  nbits;
    } cmd_t;

    // Clamp a bit count to the widest field
    function automatic logic [5:0] sat_bits(input logic [5:0] n);
        sat_bits = (n > 6'(MAX_FIELD_BITS)) ? 6'(MAX_FIELD_BITS) : n;
    endfunction

    // Bit length, one for zero
    function automatic logic [5:0] bit_len(input logic [31:0] x);
        logic [5:0] n;
        n = 6'd1;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                n = 6'(i + 1);
            end
        end
        bit_len = n;
    endfunction

endpackage

// File: hw/rtl/msb_first_bit_packer_unit.sv
`timescale 1ns / 1ps
// MSB-first bit packer: input queue port, capacity register, result queue port.
//
// Input side: drive item and raise push; the beat is taken when full is low.
// Modes are start, raw bits, ranged integer, align and flush.
// Result side: while empty is low the oldest result sits on result; pop takes it.
// Each item gives one result per completed byte (up to four), or a single
// result with byte_valid low; last marks the final result of an item.
// Configuration: cfg_data is the capacity in bytes, taken on cfg_valid with
// cfg_ready (always high). Write it only while the block is idle.
// Path: each item is registered in the front stage, then queued as a command,
// and the back end writes its results into the result queue. The back end emits
// one result beat per cycle while the result queue has room; front and back overlap.
// A stalled receiver fills the result queue, then the command queue, then
// full rises; nothing is dropped.
// Reset: position and partial byte clear, capacity 1024, overflow clear.
module msb_first_bit_packer_unit #(
    parameter int CMD_DEPTH = mbp_pkg::CMD_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mbp_pkg::in_t  item,
    output logic          full,
    input  logic          pop,
    output mbp_pkg::res_t result,
    output logic          empty,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [16:0]   cfg_data
);
    import mbp_pkg::*;

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(res_t);

    logic [16:0]      cap_reg;
    logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
    cmd_t             cmd_in, cmd_out;
    logic [CMD_W-1:0] cmd_rd;
    logic             res_push, res_full;
    res_t             res_in;
    logic [RES_W-1:0] res_rd;

    // Capacity register; the user must write it only between items, the block does not enforce this
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 17'(CAP_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    // Front: decode, clamp, field sizing
    mbp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in),
        .cmd_full (cmd_full)
    );

    // Command queue decouples front and back
    mbp_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_rd),
        .empty   (cmd_empty)
    );

    assign cmd_out = cmd_rd;

    // Back: bit position, packing, byte emission
    mbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_reg),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (res_in),
        .out_full  (res_full)
    );

    // Result queue holds finished beats while the receiver stalls
    mbp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign result = res_rd;

endmodule

// File: hw/rtl/mbp_fifo.sv
`timescale 1ns / 1ps
// Small register queue used between front, back and the result port.
module mbp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [IW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = push && !full;
    assign do_rd   = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hw/rtl/mbp_front.sv
`timescale 1ns / 1ps
// Front end: decodes items, clamps ranged integers, sizes fields into commands.
module mbp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mbp_pkg::in_t  item,
    output logic          full,
    output logic          cmd_push,
    output mbp_pkg::cmd_t cmd,
    input  logic          cmd_full
);
    import mbp_pkg::*;

    logic        s1_valid_reg;
    logic [2:0]  s1_op_reg;
    logic [31:0] s1_data_reg;
    logic [31:0] s1_span_reg;
    logic [5:0]  s1_n_reg;
    logic        s1_ranged_reg;

    logic        take;
    logic [2:0]  op_d;
    logic        ranged_d;
    logic        gt_max, lt_min, inverted;
    logic [31:0] span_d, off_d, data_d;

    // Stage 1 frees up whenever its command moves into the queue
    assign full = s1_valid_reg && cmd_full;
    assign take = push && !full;

    always_comb
    begin
        ranged_d = 1'b0;
        case (item.mode)
            MODE_START:  op_d = CMD_START;
            MODE_RAW:    op_d = CMD_WRITE;
            MODE_RANGED:
            begin
                op_d     = CMD_WRITE;
                ranged_d = 1'b1;
            end
            MODE_ALIGN:  op_d = CMD_ALIGN;
            MODE_FLUSH:  op_d = CMD_FLUSH;
            default:     op_d = CMD_NOP;
        endcase
    end

    // Clamp: an inverted range always lands on range_max
    assign gt_max   = $signed(item.value) > $signed(item.range_max);
    assign lt_min   = $signed(item.value) < $signed(item.range_min);
    assign inverted = $signed(item.range_min) > $signed(item.range_max);
    assign span_d   = item.range_max - item.range_min;
    assign off_d    = (gt_max || inverted) ? span_d :
                      (lt_min ? 32'd0 : item.value - item.range_min);
    assign data_d   = ranged_d ? off_d : item.value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (!cmd_full)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_op_reg     <= op_d;
            s1_data_reg   <= data_d;
            s1_span_reg   <= span_d;
            s1_n_reg      <= sat_bits(item.bit_count);
            s1_ranged_reg <= ranged_d;
        end
    end

    assign cmd_push  = s1_valid_reg;
    assign cmd.op    = s1_op_reg;
    assign cmd.data  = s1_data_reg;
    assign cmd.nbits = s1_ranged_reg ? sat_bits(bit_len(s1_span_reg)) : s1_n_reg;

endmodule

// File: hw/rtl/mbp_back.sv
`timescale 1ns / 1ps
// Back end: holds the bit position and partial byte, emits one result beat a cycle while the result queue has room.
module mbp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [16:0]   cap,
    input  mbp_pkg::cmd_t cmd,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    output logic          res_push,
    output mbp_pkg::res_t res,
    input  logic          out_full
);
    import mbp_pkg::*;

    logic [19:0] bp_reg, bp_next;
    logic [7:0]  partial_reg, partial_next;
    logic        ovf_reg, ovf_next;
    logic        busy_reg, busy_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  left_reg, left_next;
    logic [15:0] addr_reg, addr_next;

    logic [16:0] eff_cap;
    logic [17:0] need;
    logic        too_big;
    logic [31:0] dl;
    logic [39:0] acc;
    logic [2:0]  nb;
    logic        r_byte, r_last;
    logic [15:0] r_addr;
    logic [7:0]  r_data;

    assign eff_cap = (cap > CAP_LIMIT) ? CAP_LIMIT : cap;
    assign need    = 18'(({1'b0, bp_reg} + 21'(cmd.nbits) + 21'd7) >> 3);
    assign too_big = need > {1'b0, eff_cap};

    // Field left-aligned, then placed behind the bits already in the byte
    assign dl  = cmd.data << (6'd32 - cmd.nbits);
    assign acc = {partial_reg, 32'd0} | ({dl, 8'd0} >> bp_reg[2:0]);
    assign nb  = 3'((7'(bp_reg[2:0]) + 7'(cmd.nbits)) >> 3);

    always_comb
    begin
        bp_next      = bp_reg;
        partial_next = partial_reg;
        ovf_next     = ovf_reg;
        busy_next    = busy_reg;
        acc_next     = acc_reg;
        left_next    = left_reg;
        addr_next    = addr_reg;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        r_byte       = 1'b0;
        r_addr       = '0;
        r_data       = '0;
        r_last       = 1'b1;
        if (busy_reg)
        begin
            if (!out_full)
            begin
                res_push  = 1'b1;
                r_byte    = 1'b1;
                r_addr    = addr_reg;
                r_data    = acc_reg[31:24];
                r_last    = (left_reg == 2'd1);
                acc_next  = {acc_reg[23:0], 8'd0};
                addr_next = addr_reg + 16'd1;
                left_next = left_reg - 2'd1;
                if (left_reg == 2'd1)
                begin
                    busy_next    = 1'b0;
                    partial_next = acc_reg[23:16];
                end
            end
        end
        else if (!cmd_empty && !out_full)
        begin
            cmd_pop  = 1'b1;
            res_push = 1'b1;
            case (cmd.op)
                CMD_START:
                begin
                    bp_next      = '0;
                    partial_next = '0;
                    ovf_next     = (eff_cap == '0);
                end
                CMD_WRITE:
                begin
                    if (!ovf_reg)
                    begin
                        if (too_big)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            bp_next = bp_reg + 20'(cmd.nbits);
                            if (nb == 3'd0)
                            begin
                                partial_next = acc[39:32];
                            end
                            else
                            begin
                                r_byte = 1'b1;
                                r_addr = bp_reg[18:3];
                                r_data = acc[39:32];
                                r_last = (nb == 3'd1);
                                if (nb == 3'd1)
                                begin
                                    partial_next = acc[31:24];
                                end
                                else
                                begin
                                    busy_next = 1'b1;
                                    acc_next  = acc[31:0];
                                    left_next = 2'(nb - 3'd1);
                                    addr_next = bp_reg[18:3] + 16'd1;
                                end
                            end
                        end
                    end
                end
                CMD_ALIGN:
                begin
                    if (bp_reg[2:0] != 3'd0)
                    begin
                        bp_next      = {bp_reg[19:3] + 17'd1, 3'd0};
                        r_byte       = 1'b1;
                        r_addr       = bp_reg[18:3];
                        r_data       = partial_reg;
                        partial_next = '0;
                    end
                end
                CMD_FLUSH:
                begin
                    if (bp_reg[2:0] != 3'd0)
                    begin
                        r_byte = 1'b1;
                        r_addr = bp_reg[18:3];
                        r_data = partial_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Status is the state after the whole item; unchanged during busy beats
    assign res.byte_valid   = r_byte;
    assign res.byte_address = r_addr;
    assign res.byte_data    = r_data;
    assign res.overflow     = ovf_next;
    assign res.bits_written = bp_next;
    assign res.last         = r_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg      <= '0;
            partial_reg <= '0;
            ovf_reg     <= (CAP_RESET == 0);
            busy_reg    <= 1'b0;
            left_reg    <= '0;
        end
        else
        begin
            bp_reg      <= bp_next;
            partial_reg <= partial_next;
            ovf_reg     <= ovf_next;
            busy_reg    <= busy_next;
            left_reg    <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        addr_reg <= addr_next;
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the MSB-first bit packer, with an in-bench packing predictor.
module tb;
    import mbp_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    in_t         item      = '0;
    logic        full;
    logic        pop       = 1'b0;
    res_t        result;
    logic        empty;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_data  = '0;

    // Bench controls, all driven with NBAs at the clock edge
    logic calm    = 1'b0;   // no idling on either side while high
    logic rx_hold = 1'b0;   // receiver holds pop low while high

    msb_first_bit_packer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .pop       (pop),
        .result    (result),
        .empty     (empty),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, far past a normal run
    initial begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Packing predictor: its own copy of position, partial byte, sticky
    // overflow and capacity. Every accepted item appends its beats to
    // byte_writes_due in the order the block must produce them.
    // ------------------------------------------------------------------
    int unsigned pk_pos;
    logic [7:0]  pk_acc;
    bit          pk_ovf;
    int unsigned pk_cap;
    res_t        item_beats[$];
    res_t        byte_writes_due[$];

    // Statistics for the closing summary
    int errors;
    int items_sent;
    int beats_checked;
    int bytes_checked;
    int overflow_beats;
    int input_stalls;

    function automatic int unsigned usable_bytes();
        return (pk_cap > CAP_LIMIT_INT) ? CAP_LIMIT_INT : pk_cap;
    endfunction

    // At most four byte beats per item
    function automatic void emit_byte(input int unsigned addr, input logic [7:0] data);
        res_t b;
        b = '0;
        b.byte_valid   = 1'b1;
        b.byte_address = addr[15:0];
        b.byte_data    = data;
        if (item_beats.size() < 4)
            item_beats.push_back(b);
    endfunction

    // Number of bits needed for span; a zero span still takes one bit
    function automatic int unsigned field_width(input logic [31:0] span);
        int unsigned w;
        w = 0;
        while (span != 0) begin
            w++;
            span = span >> 1;
        end
        return (w == 0) ? 1 : w;
    endfunction

    function automatic void pack_bits(input logic [31:0] v, input int unsigned n);
        if (pk_ovf)
            return;
        if (n > MAX_FIELD_BITS)
            n = MAX_FIELD_BITS;
        // All-or-nothing: a field that does not fit trips the sticky flag
        if ((pk_pos + n + 7) / 8 > usable_bytes()) begin
            pk_ovf = 1'b1;
            return;
        end
        for (int i = n; i > 0; i--) begin
            pk_acc = pk_acc | (8'(v[i - 1]) << (7 - pk_pos % 8));
            pk_pos++;
            if (pk_pos % 8 == 0) begin
                emit_byte(pk_pos / 8 - 1, pk_acc);
                pk_acc = '0;
            end
        end
    endfunction

    function automatic void pack_item(input in_t it);
        longint      v;
        longint      lo;
        longint      hi;
        logic [31:0] span;
        logic [31:0] off;
        res_t        b;
        item_beats.delete();
        case (it.mode)
            MODE_START: begin
                pk_pos = 0;
                pk_acc = '0;
                pk_ovf = (usable_bytes() == 0);
            end
            MODE_RAW: pack_bits(it.value, it.bit_count);
            MODE_RANGED: begin
                v  = longint'($signed(it.value));
                lo = longint'($signed(it.range_min));
                hi = longint'($signed(it.range_max));
                // Clamp low first, then high: an inverted range lands on hi
                if (v < lo)
                    v = lo;
                if (v > hi)
                    v = hi;
                span = 32'(hi - lo);
                off  = 32'(v - lo);
                pack_bits(off, field_width(span));
            end
            MODE_ALIGN: begin
                if (pk_pos % 8 != 0) begin
                    pk_pos = pk_pos + 8 - pk_pos % 8;
                    emit_byte(pk_pos / 8 - 1, pk_acc);
                    pk_acc = '0;
                end
            end
            MODE_FLUSH: begin
                if (pk_pos % 8 != 0)
                    emit_byte(pk_pos / 8, pk_acc);
            end
            default: ;
        endcase
        if (item_beats.size() == 0) begin
            b = '0;
            item_beats.push_back(b);
        end
        foreach (item_beats[j]) begin
            b = item_beats[j];
            b.overflow     = pk_ovf;
            b.bits_written = pk_pos[19:0];
            b.last         = (j == item_beats.size() - 1);
            byte_writes_due.push_back(b);
        end
    endfunction

    function automatic in_t make_item(input logic [2:0] mode, input logic [31:0] value,
                                      input logic [5:0] count, input logic [31:0] lo,
                                      input logic [31:0] hi);
        in_t it;
        it.mode      = mode;
        it.value     = value;
        it.bit_count = count;
        it.range_min = lo;
        it.range_max = hi;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Result checker and receiver. Pop is redrawn every edge; a hold
    // from the pressure test forces it low.
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input res_t want, input res_t got);
        if (errors < 10) begin
            $display("%0t %s: exp v=%0d a=%h d=%h o=%0d b=%0d l=%0d", $time, what,
                     want.byte_valid, want.byte_address, want.byte_data,
                     want.overflow, want.bits_written, want.last);
            $display("%0t %s: got v=%0d a=%h d=%h o=%0d b=%0d l=%0d", $time, what,
                     got.byte_valid, got.byte_address, got.byte_data,
                     got.overflow, got.bits_written, got.last);
        end
        errors++;
    endtask

    always @(posedge clk) begin : result_check
        res_t due;
        if (rst_n && pop && !empty) begin
            if (byte_writes_due.size() == 0) begin
                flag_mismatch("unexpected beat", '0, result);
            end else begin
                due = byte_writes_due.pop_front();
                beats_checked++;
                if (due.byte_valid)
                    bytes_checked++;
                if (due.overflow)
                    overflow_beats++;
                if (result.byte_valid   !== due.byte_valid   ||
                    result.byte_address !== due.byte_address ||
                    result.byte_data    !== due.byte_data    ||
                    result.overflow     !== due.overflow     ||
                    result.bits_written !== due.bits_written ||
                    result.last         !== due.last)
                    flag_mismatch("mismatch", due, result);
            end
        end
        pop <= !rx_hold && (calm || $urandom_range(99) >= 16);
    end

    // ------------------------------------------------------------------
    // Shared sender tasks. All of them start and end on a clock edge.
    // ------------------------------------------------------------------

    // Offer one beat; push stays high on return unless an idle gap follows,
    // so a following item goes out back to back.
    task automatic send_item(input in_t it);
        item <= it;
        push <= 1'b1;
        do begin
            @(posedge clk);
            if (full)
                input_stalls++;
        end while (full);
        pack_item(it);
        items_sent++;
        if (!calm && $urandom_range(99) < 16) begin
            push <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every predicted beat has come back
    task automatic wait_drain();
        int cycles;
        push   <= 1'b0;
        cycles = 0;
        while (byte_writes_due.size() != 0 && cycles < 20000) begin
            @(posedge clk);
            cycles++;
        end
        if (byte_writes_due.size() != 0) begin
            $display("%0t %0d expected beats never arrived", $time, byte_writes_due.size());
            errors += byte_writes_due.size();
            byte_writes_due.delete();
        end
        // Slack so the block is truly idle
        repeat (6) @(posedge clk);
    endtask

    // Capacity write; only called with the block drained
    task automatic write_capacity(input logic [16:0] bytes);
        cfg_valid <= 1'b1;
        cfg_data  <= bytes;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pk_cap = bytes;
    endtask

    function automatic in_t rand_item(input int start_pct);
        in_t         it;
        int unsigned r;
        int unsigned w;
        int unsigned span;
        int unsigned lo;
        r = $urandom_range(99);
        it.value     = $urandom;
        it.bit_count = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 33))
                                                : 6'($urandom_range(32));
        it.range_min = $urandom;
        it.range_max = $urandom;
        if (r < start_pct)
            it.mode = MODE_START;
        else if (r < 45)
            it.mode = MODE_RAW;
        else if (r < 80)
            it.mode = MODE_RANGED;
        else if (r < 88)
            it.mode = MODE_ALIGN;
        else if (r < 96)
            it.mode = MODE_FLUSH;
        else
            it.mode = 3'($urandom_range(7, 5));
        // Mostly sane ranges with the value just inside or just past the ends
        if (it.mode == MODE_RANGED && $urandom_range(9) < 7) begin
            w    = $urandom_range(31);
            span = $urandom & ((32'h1 << w) - 1);
            lo   = $urandom;
            it.range_min = lo;
            it.range_max = lo + span;
            it.value     = lo + ($urandom % (span + 3)) - 1;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Raw field widths at reset capacity: full word, zero, oversized count,
    // partial byte, flush on and off a boundary, and align off a boundary
    task automatic test_raw_fields();
        send_item(make_item(MODE_START, '0, '0, '0, '0));
        send_item(make_item(MODE_RAW, 32'hFFFF_FFFF, 6'd32, '0, '0));
        send_item(make_item(MODE_RAW, 32'h0, 6'd0, '0, '0));
        send_item(make_item(MODE_RAW, 32'h8000_0001, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(MODE_RAW, 32'h5, 6'd3, '0, '0));
        send_item(make_item(MODE_FLUSH, '0, '0, '0, '0));
        send_item(make_item(MODE_ALIGN, '0, '0, '0, '0));
        send_item(make_item(MODE_FLUSH, '0, '0, '0, '0));
        send_item(make_item(MODE_RAW, 32'h1, 6'd1, '0, '0));
        wait_drain();
    endtask

    // Ranged integers: widest span, single value, inverted range, clamping
    task automatic test_ranged();
        send_item(make_item(MODE_RANGED, 32'hDEAD_BEEF, '0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(make_item(MODE_RANGED, 32'd9, '0, 32'd5, 32'd5));
        send_item(make_item(MODE_RANGED, 32'd0, '0, 32'd10, -32'sd10));
        send_item(make_item(MODE_RANGED, -32'sd100, '0, -32'sd5, 32'd20));
        send_item(make_item(MODE_RANGED, 32'd1000, '0, 32'd0, 32'd255));
        send_item(make_item(MODE_ALIGN, '0, '0, '0, '0));
        wait_drain();
    endtask

    // Capacity corners: zero, capacity lowered mid-buffer, value past the
    // address space
    task automatic test_capacity();
        write_capacity(17'd0);
        send_item(make_item(MODE_START, '0, '0, '0, '0));
        send_item(make_item(MODE_RAW, 32'hAB, 6'd8, '0, '0));
        send_item(make_item(MODE_FLUSH, '0, '0, '0, '0));
        wait_drain();
        write_capacity(17'd4);
        send_item(make_item(MODE_START, '0, '0, '0, '0));
        send_item(make_item(MODE_RAW, 32'hF_0F0F, 6'd20, '0, '0));
        wait_drain();
        // Zero-width write against the lowered capacity trips overflow;
        // align still pads out the byte afterwards
        write_capacity(17'd2);
        send_item(make_item(MODE_RAW, 32'h0, 6'd0, '0, '0));
        send_item(make_item(MODE_ALIGN, '0, '0, '0, '0));
        send_item(make_item(MODE_FLUSH, '0, '0, '0, '0));
        wait_drain();
        write_capacity(17'h1_FFFF);
        send_item(make_item(MODE_START, '0, '0, '0, '0));
        send_item(make_item(MODE_RAW, 32'h1234_5678, 6'd32, '0, '0));
        wait_drain();
    endtask

    // Codes 5..7 must be ignored but still answer with a status beat
    task automatic test_unknown_modes();
        send_item(make_item(3'd5, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(3'd6, 32'h0, 6'd32, '0, '0));
        send_item(make_item(3'd7, 32'hA5A5_A5A5, 6'd17, 32'h8000_0000, 32'h7FFF_FFFF));
        wait_drain();
    endtask

    task automatic test_random(input int n, input logic [16:0] bytes, input int start_pct,
                               input bit quiet);
        calm <= quiet;
        write_capacity(bytes);
        send_item(make_item(MODE_START, '0, '0, '0, '0));
        repeat (n) send_item(rand_item(start_pct));
        calm <= 1'b0;
        wait_drain();
    endtask

    // Receiver holds off while full-word writes keep coming, so the block
    // backs up all the way to its input
    task automatic test_backpressure();
        write_capacity(17'd1024);
        calm    <= 1'b1;
        rx_hold <= 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        send_item(make_item(MODE_START, '0, '0, '0, '0));
        repeat (40) send_item(make_item(MODE_RAW, $urandom, 6'd32, '0, '0));
        calm <= 1'b0;
        // Sender sits idle here until the last beat is back
        wait_drain();
    endtask

    initial begin
        errors         = 0;
        items_sent     = 0;
        beats_checked  = 0;
        bytes_checked  = 0;
        overflow_beats = 0;
        input_stalls   = 0;
        pk_cap         = CAP_RESET;
        pk_pos         = 0;
        pk_acc         = '0;
        pk_ovf         = (usable_bytes() == 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_raw_fields();
        test_ranged();
        test_unknown_modes();
        test_capacity();
        test_random(60, 17'd1024, 3, 1'b0);
        test_random(50, 17'd16, 10, 1'b0);
        test_random(40, 17'd65536, 2, 1'b0);
        test_random(30, 17'h1_FFFF, 3, 1'b0);
        test_random(30, 17'd1, 15, 1'b0);
        test_random(20, 17'd0, 5, 1'b0);
        test_random(40, 17'd200, 4, 1'b1);
        test_backpressure();

        // Any stray beat after the drain shows up in the checker
        repeat (20) @(posedge clk);

        $display("Run: %0d items, %0d beats checked (%0d byte writes, %0d with overflow set)",
                 items_sent, beats_checked, bytes_checked, overflow_beats);
        $display("Capacities 0 to 131071, lowered mid-buffer; %0d input stall cycles seen",
                 input_stalls);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: msb_first_bit_packer_unit.f
hw/rtl/mbp_pkg.sv
hw/rtl/mbp_fifo.sv
hw/rtl/mbp_front.sv
hw/rtl/mbp_back.sv
hw/rtl/msb_first_bit_packer_unit.sv
test/tb.sv
